@@ hw/rtl/etb_pkg.sv @@
// Shared constants, types and a function for the Euler-to-basis-vector block.
package etb_pkg;

	localparam int FRAC_BITS_DEF  = 14;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int ITERS          = 30;
	localparam int ZW             = 32;
	localparam int XW             = 33;
	localparam int LIM_W          = 10;
	localparam logic [LIM_W-1:0] LIM_RESET = 10'd2;
	localparam logic signed [XW-1:0] X_INIT = 33'sd652032874;

	localparam logic [1:0] ADDR_LIMIT = 2'd0;

	// arctangent of 2^-i, 2^30 = 90 degrees scaled phase units
	function automatic logic signed [ZW-1:0] atan_at(input int i);
		logic signed [ZW-1:0] t [ITERS];
		t = '{32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
			32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
			32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
			32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
			32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
			32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051,
			32'sh00000029, 32'sh00000014, 32'sh0000000A, 32'sh00000005,
			32'sh00000003, 32'sh00000001};
		return t[i];
	endfunction

	// one rotation lane of a CORDIC cell
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [1:0]           q;
	} lane_t;

	typedef struct packed {
		lane_t p;
		lane_t yw;
		lane_t r;
	} cell_data_t;

endpackage

@@ hw/rtl/etb_cordic_cell.sv @@
// One CORDIC micro-rotation cell for three angle lanes, registered.
module etb_cordic_cell import etb_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       vin,
	input  cell_data_t din,
	output logic       vout,
	output cell_data_t dout
);

	function automatic lane_t rot(input lane_t a);
		lane_t o;
		logic signed [XW-1:0] dx, dy;
		dx = a.y >>> STEP;
		dy = a.x >>> STEP;
		o = a;
		if (!a.z[ZW-1]) begin
			o.x = a.x - dx; o.y = a.y + dy; o.z = a.z - atan_at(STEP);
		end else begin
			o.x = a.x + dx; o.y = a.y - dy; o.z = a.z + atan_at(STEP);
		end
		return o;
	endfunction

	// valid travels with data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (adv) vout <= vin;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dout.p  <= rot(din.p);
			dout.yw <= rot(din.yw);
			dout.r  <= rot(din.r);
		end
	end

endmodule

@@ hw/rtl/etb_vector_stage.sv @@
// Post-CORDIC pipeline: quadrant fix, forward, singular test, right and up.
module etb_vector_stage import etb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    vin,
	input  cell_data_t              din,
	input  logic [LIM_W-1:0]        lim,
	output logic                    vout,
	output logic signed [15:0]      o_fwd [3],
	output logic signed [15:0]      o_rgt [3],
	output logic signed [15:0]      o_up  [3],
	output logic                    o_sing
);

	localparam int W   = FRAC_BITS + 2;
	localparam int PW  = 2 * W + 2;
	localparam int SH  = 30 - FRAC_BITS;
	localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

	function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
		logic signed [XW:0] t;
		t = ($signed({v[XW-1], v}) + ((XW+1)'(1) <<< (SH - 1))) >>> SH;
		if (t > (XW+1)'(ONE)) return ONE;
		if (t < -(XW+1)'(ONE)) return -ONE;
		return W'(t);
	endfunction

	function automatic logic signed [W-1:0] fxp(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = (v + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (t > PW'(ONE)) return ONE;
		if (t < -PW'(ONE)) return -ONE;
		return W'(t);
	endfunction

	function automatic logic signed [W-1:0] satn(input logic signed [W-1:0] v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	function automatic logic signed [PW-1:0] mul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		return PW'(a) * PW'(b);
	endfunction

	// quadrant restore; returns {sin, cos}
	function automatic logic signed [2*W-1:0] sc(input lane_t l);
		logic signed [W-1:0] cs, sn;
		cs = sat_x(l.x);
		sn = sat_x(l.y);
		unique case (l.q)
			2'd0: return {sn, cs};
			2'd1: return {cs, satn(-sn)};
			2'd2: return {satn(-sn), satn(-cs)};
			default: return {satn(-cs), sn};
		endcase
	endfunction

	logic signed [W-1:0] sp_s1, cp_s1, sy_s1, cy_s1, sr_s1, cr_s1;
	logic signed [W-1:0] f_s2 [3];
	logic signed [W-1:0] vv_s2 [2];
	logic signed [W-1:0] sr_s2, cr_s2;
	logic sing_s2;
	logic signed [W-1:0] f_s3 [3], vv_s3 [2], sr_s3, cr_s3;
	logic signed [W-1:0] w_s3 [3];
	logic sing_s3;
	logic signed [W-1:0] f_s4 [3], r_s4 [3];
	logic sing_s4;
	logic [4:0] v_q;
	logic signed [W-1:0] fx_c, fy_c;
	logic signed [W:0] ax, ay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[3:0], vin};
	end
	assign vout = v_q[4];

	// stage 1: sine and cosine
	always_ff @(posedge clk) begin
		if (adv) begin
			{sp_s1, cp_s1} <= sc(din.p);
			{sy_s1, cy_s1} <= sc(din.yw);
			{sr_s1, cr_s1} <= sc(din.r);
		end
	end

	// stage 2: forward vector and singular test
	assign fx_c = fxp(mul(cp_s1, cy_s1));
	assign fy_c = fxp(mul(cp_s1, sy_s1));
	assign ax = fx_c[W-1] ? -(W+1)'(fx_c) : (W+1)'(fx_c);
	assign ay = fy_c[W-1] ? -(W+1)'(fy_c) : (W+1)'(fy_c);
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s2[0] <= fx_c;
			f_s2[1] <= fy_c;
			f_s2[2] <= satn(-sp_s1);
			sing_s2 <= (ax <= (W+1)'(lim)) && (ay <= (W+1)'(lim));
			vv_s2[0] <= (cp_s1 > 0) ? sy_s1 : -sy_s1;
			vv_s2[1] <= (cp_s1 > 0) ? -cy_s1 : cy_s1;
			sr_s2 <= sr_s1;
			cr_s2 <= cr_s1;
		end
	end

	// stage 3: w = f x v
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s3 <= f_s2;
			sing_s3 <= sing_s2;
			vv_s3 <= vv_s2;
			sr_s3 <= sr_s2;
			cr_s3 <= cr_s2;
			w_s3[0] <= fxp(-mul(f_s2[2], vv_s2[1]));
			w_s3[1] <= fxp(mul(f_s2[2], vv_s2[0]));
			w_s3[2] <= fxp(mul(f_s2[0], vv_s2[1]) - mul(f_s2[1], vv_s2[0]));
		end
	end

	logic signed [W-1:0] ux_c, uy_c;
	assign ux_c = (f_s3[2] < 0) ? cr_s3 : -cr_s3;
	assign uy_c = -sr_s3;

	// stage 4: right vector
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s4 <= f_s3;
			sing_s4 <= sing_s3;
			if (sing_s3) begin
				r_s4[0] <= fxp(-mul(f_s3[2], uy_c));
				r_s4[1] <= fxp(mul(f_s3[2], ux_c));
				r_s4[2] <= fxp(mul(f_s3[0], uy_c) - mul(f_s3[1], ux_c));
			end else begin
				r_s4[0] <= fxp(mul(vv_s3[0], cr_s3) + mul(w_s3[0], sr_s3));
				r_s4[1] <= fxp(mul(vv_s3[1], cr_s3) + mul(w_s3[1], sr_s3));
				r_s4[2] <= fxp(mul(w_s3[2], sr_s3));
			end
		end
	end

	// stage 5: up vector (saved singular up recomputed from sr/cr)
	logic signed [W-1:0] ux_s4, uy_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s4 <= ux_c;
			uy_s4 <= uy_c;
		end
	end

	logic signed [W-1:0] u_c [3];
	always_comb begin
		if (sing_s4) begin
			u_c[0] = ux_s4; u_c[1] = uy_s4; u_c[2] = '0;
		end else begin
			u_c[0] = fxp(mul(r_s4[1], f_s4[2]) - mul(r_s4[2], f_s4[1]));
			u_c[1] = fxp(mul(r_s4[2], f_s4[0]) - mul(r_s4[0], f_s4[2]));
			u_c[2] = fxp(mul(r_s4[0], f_s4[1]) - mul(r_s4[1], f_s4[0]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				o_fwd[i] <= 16'(f_s4[i]);
				o_rgt[i] <= 16'(r_s4[i]);
				o_up[i]  <= 16'(u_c[i]);
			end
			o_sing <= sing_s4;
		end
	end

endmodule

@@ hw/rtl/euler_to_basis_vectors.sv @@
// Top level: Euler angles to forward, right and up basis vectors.
// Pipeline: the accepting edge loads the first of 35 registers (30 CORDIC cells,
//   5 vector stages); throughput one transaction per cycle while not stalled.
// The whole pipeline advances together unless a result is waiting under stall.
// Reset clears all valid flags and sets near_zero_limit to 2.
module euler_to_basis_vectors import etb_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [1:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ANGLE_BITS-1:0] pitch_angle,
	input  logic [ANGLE_BITS-1:0] yaw_angle,
	input  logic [ANGLE_BITS-1:0] roll_angle,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [15:0]    fwd_x,
	output logic signed [15:0]    fwd_y,
	output logic signed [15:0]    fwd_z,
	output logic signed [15:0]    right_x,
	output logic signed [15:0]    right_y,
	output logic signed [15:0]    right_z,
	output logic signed [15:0]    up_x,
	output logic signed [15:0]    up_y,
	output logic signed [15:0]    up_z,
	output logic                  singular
);

	logic [LIM_W-1:0] lim_q;
	logic adv;

	// config register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lim_q <= LIM_RESET;
		else if (psel && penable && pwrite && paddr == ADDR_LIMIT)
			lim_q <= pwdata[LIM_W-1:0];
	end
	assign prdata = (paddr == ADDR_LIMIT) ? 32'(lim_q) : '0;

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	function automatic lane_t seed(input logic [ANGLE_BITS-1:0] a);
		lane_t l;
		logic [31:0] ph, t;
		ph = {a, {(32-ANGLE_BITS){1'b0}}} ;
		t = ph + 32'h20000000;
		l.q = t[31:30];
		l.z = $signed({2'b00, t[29:0]}) - 32'sh20000000;
		l.x = X_INIT;
		l.y = '0;
		return l;
	endfunction

	cell_data_t d [ITERS+1];
	logic v [ITERS+1];

	assign d[0] = '{p: seed(pitch_angle), yw: seed(yaw_angle), r: seed(roll_angle)};
	assign v[0] = in_valid;

	// CORDIC chain
	for (genvar g = 0; g < ITERS; g++) begin : g_cell
		etb_cordic_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vin(v[g]), .din(d[g]), .vout(v[g+1]), .dout(d[g+1])
		);
	end

	logic signed [15:0] f [3], r [3], u [3];

	etb_vector_stage #(.FRAC_BITS(FRAC_BITS)) u_vec (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(v[ITERS]), .din(d[ITERS]),
		.lim(lim_q), .vout(out_valid), .o_fwd(f), .o_rgt(r), .o_up(u),
		.o_sing(singular)
	);

	assign fwd_x = f[0];   assign fwd_y = f[1];   assign fwd_z = f[2];
	assign right_x = r[0]; assign right_y = r[1]; assign right_z = r[2];
	assign up_x = u[0];    assign up_y = u[1];    assign up_z = u[2];

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(fwd_x) && $stable(up_z) && out_valid)
		else $error("stalled result changed");
	// input stall mirrors output back-pressure
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("stall mismatch");
	// singular results have zero up_z
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> up_z == 16'sd0)
		else $error("singular up_z nonzero");

endmodule
